/* rtl/epcr_pkg.sv */
// ---------------------------------------------------------------------------
// Edge/point collision response - shared types and helpers
// Payload records that travel along the pipeline, target codes and the
// saturation helpers used by the response datapath.
// ---------------------------------------------------------------------------
package epcr_pkg;

   localparam int COORD_W = 32;
   localparam int PUSH_W  = 50;

   localparam logic [1:0] TGT_CONTACT = 2'd0;
   localparam logic [1:0] TGT_START   = 2'd1;
   localparam logic [1:0] TGT_END     = 2'd2;

   localparam logic [30:0] T_LIMIT = 31'h4000_0000;

   // point coordinates, scaled push vector and static flags of one collision
   typedef struct packed {
      logic [COORD_W-1:0] px;
      logic [COORD_W-1:0] py;
      logic [COORD_W-1:0] ax;
      logic [COORD_W-1:0] ay;
      logic [COORD_W-1:0] bx;
      logic [COORD_W-1:0] by;
      logic [PUSH_W-1:0]  nx;
      logic [PUSH_W-1:0]  ny;
      logic               fp;
      logic               fa;
      logic               fb;
   } carry_type;

   typedef struct packed {
      carry_type c;
      logic      neg;
      logic      sat;
      logic      zero;
   } div1_side_type;

   typedef struct packed {
      carry_type          c;
      logic [COORD_W-1:0] t;
      logic [COORD_W-1:0] st;
   } div2_side_type;

   // limit a 33-bit difference to +-(2^31-1)
   function automatic logic [31:0] clamp_diff(input logic signed [32:0] v);
      logic [31:0] r;
      if (v > 33'sh0_7FFF_FFFF) begin
         r = 32'h7FFF_FFFF;
      end else if (v < -33'sh0_7FFF_FFFF) begin
         r = 32'h8000_0001;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   function automatic logic [31:0] sat32(input logic signed [63:0] v);
      logic [31:0] r;
      if (v > 64'sh0000_0000_7FFF_FFFF) begin
         r = 32'h7FFF_FFFF;
      end else if (v < -64'sh0000_0000_8000_0000) begin
         r = 32'h8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

/* rtl/epcr_div.sv */
// ---------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per stage, remainder and divisor carried along, with a
// sideband word that travels beside each division. All stages share one
// advance enable.
// ---------------------------------------------------------------------------
module epcr_div #(
   parameter int W  = 64,
   parameter int QW = 31,
   parameter int PW = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          enable,
   input  logic          in_valid,
   input  logic [W-1:0]  in_rem,
   input  logic [W-1:0]  in_divisor,
   input  logic [QW-1:0] in_bits,
   input  logic [PW-1:0] in_pay,
   output logic          out_valid,
   output logic [QW-1:0] out_quot,
   output logic [PW-1:0] out_pay
);

   logic [W-1:0]  rem_ff  [QW];
   logic [W-1:0]  div_ff  [QW];
   logic [QW-1:0] bits_ff [QW];
   logic [QW-1:0] quot_ff [QW];
   logic [PW-1:0] pay_ff  [QW];
   logic [QW-1:0] valid_ff;

   logic [W-1:0]  rem_in  [QW];
   logic [W-1:0]  div_in  [QW];
   logic [QW-1:0] bits_in [QW];
   logic [QW-1:0] quot_in [QW];
   logic [PW-1:0] pay_in  [QW];

   logic [W-1:0]  src_rem  [QW];
   logic [W-1:0]  src_div  [QW];
   logic [QW-1:0] src_bits [QW];
   logic [QW-1:0] src_quot [QW];
   logic [PW-1:0] src_pay  [QW];

   always_comb begin
      src_rem[0]  = in_rem;
      src_div[0]  = in_divisor;
      src_bits[0] = in_bits;
      src_quot[0] = '0;
      src_pay[0]  = in_pay;
      for (int k = 1; k < QW; k++) begin
         src_rem[k]  = rem_ff[k-1];
         src_div[k]  = div_ff[k-1];
         src_bits[k] = bits_ff[k-1];
         src_quot[k] = quot_ff[k-1];
         src_pay[k]  = pay_ff[k-1];
      end
   end

   always_comb begin
      logic [W:0] trial;
      logic [W:0] diff;
      trial = '0;
      diff  = '0;
      for (int k = 0; k < QW; k++) begin
         trial = {src_rem[k], src_bits[k][QW-1]};
         diff  = trial - {1'b0, src_div[k]};
         // no borrow: take the subtraction and set the quotient bit
         rem_in[k]  = diff[W] ? trial[W-1:0] : diff[W-1:0];
         quot_in[k] = {src_quot[k][QW-2:0], ~diff[W]};
         bits_in[k] = src_bits[k] << 1;
         div_in[k]  = src_div[k];
         pay_in[k]  = src_pay[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (enable) begin
         valid_ff <= {valid_ff[QW-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int k = 0; k < QW; k++) begin
            rem_ff[k]  <= rem_in[k];
            div_ff[k]  <= div_in[k];
            bits_ff[k] <= bits_in[k];
            quot_ff[k] <= quot_in[k];
            pay_ff[k]  <= pay_in[k];
         end
      end
   end

   assign out_valid = valid_ff[QW-1];
   assign out_quot  = quot_ff[QW-1];
   assign out_pay   = pay_ff[QW-1];

endmodule

/* rtl/edge_point_collision_response_unit.sv */
// The two pipelined dividers have 31 and FRAC_BITS + 2 stages.
// Throughput: one collision per cycle into the pipeline while the final stage is empty or
// emptying; the single result port sends one corrected point per cycle while rsp_tready allows,
// so a collision with more than one moved point holds the pipeline until its last point is sent.
// A collision whose three points are all static is taken and produces nothing.
// Reset: synchronous; clears the valid bits and the pending result mask, data is not reset.
// ---------------------------------------------------------------------------
// Edge/point collision response unit
// Splits the push of one collision among the free contact point and edge
// end points, weighting the edge by the contact's edge parameter.
// ---------------------------------------------------------------------------
module edge_point_collision_response_unit #(
   parameter int FRAC_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   // contact_x, contact_y, edge_start_x, edge_start_y, edge_end_x, edge_end_y,
   // normal_x, normal_y, depth, contact_fixed, start_fixed, end_fixed, zero pad
   input  logic [263:0] req_tdata,
   input  logic         req_tvalid,
   output logic         req_tready,
   // target, new_x, new_y, zero pad
   output logic [71:0]  rsp_tdata,
   output logic         rsp_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready
);

   localparam int QW2  = FRAC_BITS + 2;
   localparam int WW   = FRAC_BITS + 3;
   localparam int PWW  = 32 + WW;
   localparam int NXW  = 50 - FRAC_BITS;
   localparam int MW   = WW + NXW;
   localparam int ONE  = 1 << FRAC_BITS;
   localparam int D1_W = $bits(epcr_pkg::div1_side_type);
   localparam int D2_W = $bits(epcr_pkg::div2_side_type);

   logic adv;

   // ---------------- stage 1: input register
   logic [263:0] s1_tdata_ff;
   logic         s1_v_ff;
   logic         all_fixed;

   assign all_fixed = req_tdata[259] & req_tdata[260] & req_tdata[261];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (adv) begin
         s1_v_ff <= req_tvalid & ~all_fixed;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_tdata_ff <= req_tdata;
      end
   end

   // ---------------- stage 2: push vector and clamped differences
   logic signed [17:0] nrx, nry;
   logic [30:0]        dep;
   logic signed [49:0] nprod_x, nprod_y;
   logic signed [31:0] ax1, ay1, bx1, by1, px1, py1;
   epcr_pkg::carry_type c2_in, c2_ff;
   logic [31:0]        ex_in, ey_in, qx_in, qy_in;
   logic signed [31:0] ex_ff, ey_ff, qx_ff, qy_ff;
   logic               s2_v_ff;

   assign px1 = $signed(s1_tdata_ff[31:0]);
   assign py1 = $signed(s1_tdata_ff[63:32]);
   assign ax1 = $signed(s1_tdata_ff[95:64]);
   assign ay1 = $signed(s1_tdata_ff[127:96]);
   assign bx1 = $signed(s1_tdata_ff[159:128]);
   assign by1 = $signed(s1_tdata_ff[191:160]);
   assign nrx = $signed(s1_tdata_ff[209:192]);
   assign nry = $signed(s1_tdata_ff[227:210]);
   assign dep = s1_tdata_ff[258:228];

   assign nprod_x = nrx * $signed({1'b0, dep});
   assign nprod_y = nry * $signed({1'b0, dep});

   always_comb begin
      c2_in.px = s1_tdata_ff[31:0];
      c2_in.py = s1_tdata_ff[63:32];
      c2_in.ax = s1_tdata_ff[95:64];
      c2_in.ay = s1_tdata_ff[127:96];
      c2_in.bx = s1_tdata_ff[159:128];
      c2_in.by = s1_tdata_ff[191:160];
      c2_in.nx = nprod_x >>> FRAC_BITS;
      c2_in.ny = nprod_y >>> FRAC_BITS;
      c2_in.fp = s1_tdata_ff[259];
      c2_in.fa = s1_tdata_ff[260];
      c2_in.fb = s1_tdata_ff[261];
      ex_in = epcr_pkg::clamp_diff(33'(bx1) - 33'(ax1));
      ey_in = epcr_pkg::clamp_diff(33'(by1) - 33'(ay1));
      qx_in = epcr_pkg::clamp_diff(33'(px1) - 33'(ax1));
      qy_in = epcr_pkg::clamp_diff(33'(py1) - 33'(ay1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (adv) begin
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c2_ff <= c2_in;
         ex_ff <= $signed(ex_in);
         ey_ff <= $signed(ey_in);
         qx_ff <= $signed(qx_in);
         qy_ff <= $signed(qy_in);
      end
   end

   // ---------------- stage 3: dot products
   epcr_pkg::carry_type c3_ff;
   logic signed [63:0]  pxq_ff, pyq_ff, pxx_ff, pyy_ff;
   logic                s3_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_v_ff <= 1'b0;
      end else if (adv) begin
         s3_v_ff <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c3_ff  <= c2_ff;
         pxq_ff <= ex_ff * qx_ff;
         pyq_ff <= ey_ff * qy_ff;
         pxx_ff <= ex_ff * ex_ff;
         pyy_ff <= ey_ff * ey_ff;
      end
   end

   // ---------------- edge parameter division: |num| * S / den
   logic signed [63:0] num;
   logic [63:0]        den, num_mag, num_shl, num_hi;
   epcr_pkg::div1_side_type d1_side_in, d1_side_out;
   logic [D1_W-1:0]    d1_pay_out;
   logic               d1_v;
   logic [30:0]        d1_quot;

   assign num     = pxq_ff + pyq_ff;
   assign den     = pxx_ff + pyy_ff;
   assign num_mag = num[63] ? 64'(-num) : 64'(num);
   assign num_shl = num_mag << FRAC_BITS;
   assign num_hi  = num_mag >> (31 - FRAC_BITS);

   always_comb begin
      d1_side_in.c    = c3_ff;
      d1_side_in.neg  = num[63];
      // quotient would reach 2^31 or more: clamp afterwards
      d1_side_in.sat  = num_hi >= den;
      d1_side_in.zero = den == 64'd0;
   end

   epcr_div #(
      .W  (64),
      .QW (31),
      .PW (D1_W)
   ) u_div_t (
      .clock      (clock),
      .reset      (reset),
      .enable     (adv),
      .in_valid   (s3_v_ff),
      .in_rem     (num_hi),
      .in_divisor (den),
      .in_bits    (num_shl[30:0]),
      .in_pay     (d1_side_in),
      .out_valid  (d1_v),
      .out_quot   (d1_quot),
      .out_pay    (d1_pay_out)
   );

   assign d1_side_out = epcr_pkg::div1_side_type'(d1_pay_out);

   // ---------------- stage 5: t and the lambda denominator terms
   logic [30:0]         t_mag;
   logic signed [31:0]  t_in, st_in;
   epcr_pkg::carry_type c5_ff;
   logic signed [31:0]  t5_ff, st5_ff;
   logic signed [63:0]  tt5_ff, ss5_ff;
   logic                s5_v_ff;

   always_comb begin
      if (d1_side_out.zero) begin
         t_mag = '0;
      end else if (d1_side_out.sat || d1_quot > epcr_pkg::T_LIMIT) begin
         t_mag = epcr_pkg::T_LIMIT;
      end else begin
         t_mag = d1_quot;
      end
      t_in  = d1_side_out.neg ? -$signed({1'b0, t_mag}) : $signed({1'b0, t_mag});
      st_in = 32'(ONE) - t_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_v_ff <= 1'b0;
      end else if (adv) begin
         s5_v_ff <= d1_v;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c5_ff  <= d1_side_out.c;
         t5_ff  <= t_in;
         st5_ff <= st_in;
         tt5_ff <= t_in * t_in;
         ss5_ff <= st_in * st_in;
      end
   end

   // ---------------- lambda division: S^2 / D2
   logic [63:0]      d2_sum, d2_den;
   epcr_pkg::div2_side_type d2_side_in, d2_side_out;
   logic [D2_W-1:0]  d2_pay_out;
   logic             d2_v;
   logic [QW2-1:0]   lam;

   assign d2_sum = tt5_ff + ss5_ff;
   assign d2_den = d2_sum >> FRAC_BITS;

   always_comb begin
      d2_side_in.c  = c5_ff;
      d2_side_in.t  = t5_ff;
      d2_side_in.st = st5_ff;
   end

   epcr_div #(
      .W  (64),
      .QW (QW2),
      .PW (D2_W)
   ) u_div_lam (
      .clock      (clock),
      .reset      (reset),
      .enable     (adv),
      .in_valid   (s5_v_ff),
      .in_rem     (64'd1 << (FRAC_BITS - 2)),
      .in_divisor (d2_den),
      .in_bits    ('0),
      .in_pay     (d2_side_in),
      .out_valid  (d2_v),
      .out_quot   (lam),
      .out_pay    (d2_pay_out)
   );

   assign d2_side_out = epcr_pkg::div2_side_type'(d2_pay_out);

   // ---------------- stage 6: edge weights before scaling
   epcr_pkg::carry_type c6_ff;
   logic signed [PWW-1:0] pws_ff, pwe_ff;
   logic                  s6_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s6_v_ff <= 1'b0;
      end else if (adv) begin
         s6_v_ff <= d2_v;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c6_ff  <= d2_side_out.c;
         pws_ff <= $signed(d2_side_out.st) * $signed({1'b0, lam});
         pwe_ff <= $signed(d2_side_out.t) * $signed({1'b0, lam});
      end
   end

   // ---------------- stage 7: weighted push components
   logic signed [WW-1:0]  ws, we;
   logic signed [NXW-1:0] nx6, ny6;
   epcr_pkg::carry_type   c7_ff;
   logic signed [MW-1:0]  mxs_ff, mys_ff, mxe_ff, mye_ff;
   logic                  s7_v_ff;

   assign ws  = $signed(pws_ff[2*FRAC_BITS+2:FRAC_BITS]);
   assign we  = $signed(pwe_ff[2*FRAC_BITS+2:FRAC_BITS]);
   assign nx6 = $signed(c6_ff.nx[NXW-1:0]);
   assign ny6 = $signed(c6_ff.ny[NXW-1:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         s7_v_ff <= 1'b0;
      end else if (adv) begin
         s7_v_ff <= s6_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         c7_ff  <= c6_ff;
         mxs_ff <= ws * nx6;
         mys_ff <= ws * ny6;
         mxe_ff <= we * nx6;
         mye_ff <= we * ny6;
      end
   end

   // ---------------- final stage: corrected positions, held while serialized
   logic                 both_free, edge_fixed;
   logic signed [MW-1:0] dxs, dys, dxe, dye;
   logic signed [49:0]   cnx, cny;
   logic signed [63:0]   r0x, r0y, r1x, r1y, r2x, r2y;
   logic [31:0]          fx_in [3];
   logic [31:0]          fy_in [3];
   logic [31:0]          fx_ff [3];
   logic [31:0]          fy_ff [3];
   logic [2:0]           mask_in, mask_ff, mask_new, pick, rest;
   logic                 fin_v_ff, fin_v_in;
   logic                 slot_free, pop, fin_done;

   assign both_free  = ~c7_ff.fp & ~c7_ff.fa & ~c7_ff.fb;
   assign edge_fixed = c7_ff.fa & c7_ff.fb;

   always_comb begin
      dxs = both_free ? (mxs_ff >>> (FRAC_BITS + 1)) : (mxs_ff >>> FRAC_BITS);
      dys = both_free ? (mys_ff >>> (FRAC_BITS + 1)) : (mys_ff >>> FRAC_BITS);
      dxe = both_free ? (mxe_ff >>> (FRAC_BITS + 1)) : (mxe_ff >>> FRAC_BITS);
      dye = both_free ? (mye_ff >>> (FRAC_BITS + 1)) : (mye_ff >>> FRAC_BITS);
      // contact takes the full push only against a fully static edge
      cnx = edge_fixed ? $signed(c7_ff.nx) : ($signed(c7_ff.nx) >>> 1);
      cny = edge_fixed ? $signed(c7_ff.ny) : ($signed(c7_ff.ny) >>> 1);
      r0x = $signed(c7_ff.px) + cnx;
      r0y = $signed(c7_ff.py) + cny;
      r1x = $signed(c7_ff.ax) - dxs;
      r1y = $signed(c7_ff.ay) - dys;
      r2x = $signed(c7_ff.bx) - dxe;
      r2y = $signed(c7_ff.by) - dye;
      fx_in[0] = epcr_pkg::sat32(r0x);
      fy_in[0] = epcr_pkg::sat32(r0y);
      fx_in[1] = epcr_pkg::sat32(r1x);
      fy_in[1] = epcr_pkg::sat32(r1y);
      fx_in[2] = epcr_pkg::sat32(r2x);
      fy_in[2] = epcr_pkg::sat32(r2y);
      mask_new = {~c7_ff.fb, ~c7_ff.fa, ~c7_ff.fp};
   end

   // ---------------- serializer and output register
   logic [1:0]  tgt_sel;
   logic [31:0] x_sel, y_sel;
   logic        rsp_tvalid_ff, rsp_tvalid_in, rsp_tlast_ff;
   logic [71:0] rsp_tdata_ff;

   always_comb begin
      if (mask_ff[0]) begin
         pick    = 3'b001;
         tgt_sel = epcr_pkg::TGT_CONTACT;
         x_sel   = fx_ff[0];
         y_sel   = fy_ff[0];
      end else if (mask_ff[1]) begin
         pick    = 3'b010;
         tgt_sel = epcr_pkg::TGT_START;
         x_sel   = fx_ff[1];
         y_sel   = fy_ff[1];
      end else begin
         pick    = 3'b100;
         tgt_sel = epcr_pkg::TGT_END;
         x_sel   = fx_ff[2];
         y_sel   = fy_ff[2];
      end
      rest      = mask_ff & ~pick;
      slot_free = ~rsp_tvalid_ff | rsp_tready;
      pop       = fin_v_ff & slot_free;
      fin_done  = pop & (rest == 3'b000);
      // advance the whole pipeline when the final stage empties or is empty
      adv       = ~fin_v_ff | fin_done;
      fin_v_in  = adv ? s7_v_ff : fin_v_ff;
      if (adv) begin
         mask_in = mask_new;
      end else if (pop) begin
         mask_in = rest;
      end else begin
         mask_in = mask_ff;
      end
      if (pop) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end else begin
         rsp_tvalid_in = rsp_tvalid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_v_ff      <= 1'b0;
         mask_ff       <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         fin_v_ff      <= fin_v_in;
         mask_ff       <= mask_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 3; k++) begin
            fx_ff[k] <= fx_in[k];
            fy_ff[k] <= fy_in[k];
         end
      end
      if (pop) begin
         rsp_tdata_ff <= {6'd0, y_sel, x_sel, tgt_sel};
         rsp_tlast_ff <= rest == 3'b000;
      end
   end

   assign req_tready = adv;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;

   // ---------------- checks
   a_fin_mask_set: assert property (@(posedge clock) disable iff (reset)
      fin_v_ff |-> mask_ff != 3'b000)
      else $error("held collision has no pending result");

   a_mask_shrinks: assert property (@(posedge clock) disable iff (reset)
      fin_v_ff && !adv |=> (mask_ff & ~$past(mask_ff)) == 3'b000)
      else $error("pending result mask grew while held");

   a_last_on_done: assert property (@(posedge clock) disable iff (reset)
      pop |=> rsp_tvalid && rsp_tlast == $past(fin_done))
      else $error("tlast does not match end of collision");

endmodule
